### sv/e2bv_pkg.sv
// ----------------------------------------------------------------------------
// e2bv_pkg
// Shared types, constants and elaboration-time sine table arithmetic for the
// Euler-angle to basis-vector pipeline.
// ----------------------------------------------------------------------------
package e2bv_pkg;

    // Width of each angle field on the input channel
    localparam int ANGLE_IN_W = 16;
    // Width and scale of each vector component on the output channel
    localparam int OUT_W      = 16;
    localparam int OUT_FRAC   = 14;
    localparam int OUT_ONE    = 16384;

    // pi/2 in unsigned Q2.62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // Per-stage load enables, one for each register stage of the pipeline
    typedef struct packed {
        logic idx;   // quadrant and table index
        logic rom;   // table read
        logic quad;  // quadrant folding into sin and cos
        logic prod;  // two-factor products
        logic term;  // three-factor products
        logic fmt;   // sums, clamp and output format
    } t_stage_en;

    // One result word: forward, right and up vectors in signed Q1.14
    typedef struct packed {
        logic signed [OUT_W-1:0] forward_x;
        logic signed [OUT_W-1:0] forward_y;
        logic signed [OUT_W-1:0] forward_z;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] right_y;
        logic signed [OUT_W-1:0] right_z;
        logic signed [OUT_W-1:0] up_x;
        logic signed [OUT_W-1:0] up_y;
        logic signed [OUT_W-1:0] up_z;
    } t_basis;

    // Bits 125:62 of a Q2.62 by Q2.62 product, kept at Q2.62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Restoring division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table entry k: sin(pi/2 * k / 2^tbits) rounded to fbits fraction bits
    function automatic logic [63:0] table_entry(input logic [63:0] k, input int tbits,
                                                input int fbits);
        logic [63:0] mask;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] den;
        mask = (64'd1 << tbits) - 64'd1;
        if (k == 64'd0) begin
            return 64'd0;
        end
        if (k >= (64'd1 << tbits)) begin
            return 64'd1 << fbits;
        end
        x    = (HALF_PI_Q62 >> tbits) * k + (((HALF_PI_Q62 & mask) * k) >> tbits);
        x2   = mul_q62(x, x);
        term = x;
        s    = x;
        // Taylor series; terms alternate in sign, odd steps subtract
        for (int n = 1; n < 40; n++) begin
            den  = 64'(2 * n) * 64'(2 * n + 1);
            term = udiv64(mul_q62(term, x2), den);
            if (n % 2 == 1) begin
                s = s - term;
            end else begin
                s = s + term;
            end
        end
        s = (s + (64'd1 << (61 - fbits))) >> (62 - fbits);
        if (s > (64'd1 << fbits)) begin
            s = 64'd1 << fbits;
        end
        return s;
    endfunction

endpackage

### sv/e2bv_if.sv
// ----------------------------------------------------------------------------
// e2bv channel interfaces
// Valid/ready channels for the angle words in and the basis words out.
// ----------------------------------------------------------------------------
interface e2bv_angles_if;
    logic                                valid;
    logic                                ready;
    logic [e2bv_pkg::ANGLE_IN_W-1:0]     pitch_angle;
    logic [e2bv_pkg::ANGLE_IN_W-1:0]     yaw_angle;
    logic [e2bv_pkg::ANGLE_IN_W-1:0]     roll_angle;

    modport source (output valid, output pitch_angle, output yaw_angle, output roll_angle,
                    input ready);
    modport sink   (input valid, input pitch_angle, input yaw_angle, input roll_angle,
                    output ready);
endinterface

interface e2bv_basis_if;
    logic                                valid;
    logic                                ready;
    logic signed [e2bv_pkg::OUT_W-1:0]   forward_x;
    logic signed [e2bv_pkg::OUT_W-1:0]   forward_y;
    logic signed [e2bv_pkg::OUT_W-1:0]   forward_z;
    logic signed [e2bv_pkg::OUT_W-1:0]   right_x;
    logic signed [e2bv_pkg::OUT_W-1:0]   right_y;
    logic signed [e2bv_pkg::OUT_W-1:0]   right_z;
    logic signed [e2bv_pkg::OUT_W-1:0]   up_x;
    logic signed [e2bv_pkg::OUT_W-1:0]   up_y;
    logic signed [e2bv_pkg::OUT_W-1:0]   up_z;

    modport source (output valid, output forward_x, output forward_y, output forward_z,
                    output right_x, output right_y, output right_z,
                    output up_x, output up_y, output up_z, input ready);
    modport sink   (input valid, input forward_x, input forward_y, input forward_z,
                    input right_x, input right_y, input right_z,
                    input up_x, input up_y, input up_z, output ready);
endinterface

### sv/e2bv_sincos.sv
// ----------------------------------------------------------------------------
// e2bv_sincos
// Three register stages: quadrant and table index, quarter-wave table read,
// quadrant folding into sine and cosine for pitch, yaw and roll.
// ----------------------------------------------------------------------------
module e2bv_sincos #(
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10,
    parameter int FRAC_BITS       = 14
) (
    input  logic                            i_clk,
    input  e2bv_pkg::t_stage_en             i_en,
    input  logic [e2bv_pkg::ANGLE_IN_W-1:0] i_angle [3],
    output logic signed [FRAC_BITS+1:0]     o_sin   [3],
    output logic signed [FRAC_BITS+1:0]     o_cos   [3]
);

    localparam int AW = ANGLE_BITS;
    localparam int TB = SINE_TABLE_BITS;
    localparam int TI = TB + 1;
    localparam int FW = FRAC_BITS + 2;
    localparam int Q  = 1 << TB;
    localparam int D  = AW - 2 - TB;

    typedef logic signed [FW-1:0] t_tab [0:Q];

    // Build the quarter-wave table at elaboration
    function automatic t_tab build_tab();
        t_tab t;
        for (int k = 0; k <= Q; k++) begin
            t[k] = FW'(e2bv_pkg::table_entry(64'(k), TB, FRAC_BITS));
        end
        return t;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    logic [1:0]           r_quad1 [3];
    logic [TI-1:0]        r_si    [3];
    logic [TI-1:0]        r_ci    [3];
    logic [1:0]           r_quad2 [3];
    logic signed [FW-1:0] r_ts    [3];
    logic signed [FW-1:0] r_tc    [3];
    logic signed [FW-1:0] r_sin   [3];
    logic signed [FW-1:0] r_cos   [3];

    for (genvar g = 0; g < 3; g++) begin : g_axis
        logic [AW-1:0] angle;
        logic [TI-1:0] idx;
        logic signed [FW-1:0] n_sin;
        logic signed [FW-1:0] n_cos;

        assign angle = AW'(i_angle[g]);

        // Round the in-quadrant position to a table index, or widen it
        if (D > 0) begin : g_round
            logic [AW-2:0] sum;
            assign sum = {1'b0, angle[AW-3:0]} + ((AW - 1)'(1) << (D - 1));
            assign idx = TI'(sum >> D);
        end else begin : g_widen
            assign idx = TI'(angle[AW-3:0]) << (TB - (AW - 2));
        end

        // Fold the quadrant into signs and a sine/cosine swap
        always_comb begin
            unique case (r_quad2[g])
                2'd0: begin
                    n_sin = r_ts[g];
                    n_cos = r_tc[g];
                end
                2'd1: begin
                    n_sin = r_tc[g];
                    n_cos = -r_ts[g];
                end
                2'd2: begin
                    n_sin = -r_ts[g];
                    n_cos = -r_tc[g];
                end
                default: begin
                    n_sin = -r_tc[g];
                    n_cos = r_ts[g];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_en.idx) begin
                r_quad1[g] <= angle[AW-1:AW-2];
                r_si[g]    <= idx;
                r_ci[g]    <= TI'(Q) - idx;
            end
            if (i_en.rom) begin
                r_quad2[g] <= r_quad1[g];
                r_ts[g]    <= SINE_TAB[r_si[g]];
                r_tc[g]    <= SINE_TAB[r_ci[g]];
            end
            if (i_en.quad) begin
                r_sin[g] <= n_sin;
                r_cos[g] <= n_cos;
            end
        end

        assign o_sin[g] = r_sin[g];
        assign o_cos[g] = r_cos[g];
    end

endmodule

### sv/e2bv_mult.sv
// ----------------------------------------------------------------------------
// e2bv_mult
// Two register stages of rounded fixed-point products: all two-factor terms
// first, then the four three-factor terms of the right and up vectors.
// ----------------------------------------------------------------------------
module e2bv_mult #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  e2bv_pkg::t_stage_en         i_en,
    input  logic signed [FRAC_BITS+1:0] i_sin [3],
    input  logic signed [FRAC_BITS+1:0] i_cos [3],
    output logic signed [FRAC_BITS+1:0] o_sp,
    output logic signed [FRAC_BITS+1:0] o_cpcy,
    output logic signed [FRAC_BITS+1:0] o_cpsy,
    output logic signed [FRAC_BITS+1:0] o_crsy,
    output logic signed [FRAC_BITS+1:0] o_crcy,
    output logic signed [FRAC_BITS+1:0] o_srcp,
    output logic signed [FRAC_BITS+1:0] o_srsy,
    output logic signed [FRAC_BITS+1:0] o_srcy,
    output logic signed [FRAC_BITS+1:0] o_crcp,
    output logic signed [FRAC_BITS+1:0] o_srspcy,
    output logic signed [FRAC_BITS+1:0] o_srspsy,
    output logic signed [FRAC_BITS+1:0] o_crspcy,
    output logic signed [FRAC_BITS+1:0] o_crspsy
);

    localparam int F  = FRAC_BITS;
    localparam int FW = F + 2;
    localparam logic [2*FW-1:0] HALF = (2 * FW)'(1) << (F - 1);

    // Product of two fractions, magnitude rounded half away from zero
    function automatic logic signed [FW-1:0] mulq(input logic signed [FW-1:0] a,
                                                  input logic signed [FW-1:0] b);
        logic            neg;
        logic [FW-1:0]   ma;
        logic [FW-1:0]   mb;
        logic [2*FW-1:0] p;
        logic [FW-1:0]   r;
        neg = a[FW-1] ^ b[FW-1];
        ma  = a[FW-1] ? FW'(-a) : FW'(a);
        mb  = b[FW-1] ? FW'(-b) : FW'(b);
        p   = {{FW{1'b0}}, ma} * {{FW{1'b0}}, mb};
        p   = p + HALF;
        r   = FW'(p >> F);
        return neg ? $signed(-r) : $signed(r);
    endfunction

    // Axis order: pitch, yaw, roll
    logic signed [FW-1:0] sp, cp, sy, cy, sr, cr;
    assign sp = i_sin[0];
    assign cp = i_cos[0];
    assign sy = i_sin[1];
    assign cy = i_cos[1];
    assign sr = i_sin[2];
    assign cr = i_cos[2];

    logic signed [FW-1:0] r_srsp, r_crsp, r_sy4, r_cy4, r_sp4;
    logic signed [FW-1:0] r_cpcy4, r_cpsy4, r_crsy4, r_crcy4, r_srcp4, r_srsy4, r_srcy4, r_crcp4;
    logic signed [FW-1:0] r_sp, r_cpcy, r_cpsy, r_crsy, r_crcy, r_srcp, r_srsy, r_srcy, r_crcp;
    logic signed [FW-1:0] r_srspcy, r_srspsy, r_crspcy, r_crspsy;

    // Form the two-factor products
    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_srsp  <= mulq(sr, sp);
            r_crsp  <= mulq(cr, sp);
            r_cpcy4 <= mulq(cp, cy);
            r_cpsy4 <= mulq(cp, sy);
            r_crsy4 <= mulq(cr, sy);
            r_crcy4 <= mulq(cr, cy);
            r_srcp4 <= mulq(sr, cp);
            r_srsy4 <= mulq(sr, sy);
            r_srcy4 <= mulq(sr, cy);
            r_crcp4 <= mulq(cr, cp);
            r_sp4   <= sp;
            r_sy4   <= sy;
            r_cy4   <= cy;
        end
    end

    // Form the three-factor products, carry the rest along
    always_ff @(posedge i_clk) begin
        if (i_en.term) begin
            r_srspcy <= mulq(r_srsp, r_cy4);
            r_srspsy <= mulq(r_srsp, r_sy4);
            r_crspcy <= mulq(r_crsp, r_cy4);
            r_crspsy <= mulq(r_crsp, r_sy4);
            r_sp     <= r_sp4;
            r_cpcy   <= r_cpcy4;
            r_cpsy   <= r_cpsy4;
            r_crsy   <= r_crsy4;
            r_crcy   <= r_crcy4;
            r_srcp   <= r_srcp4;
            r_srsy   <= r_srsy4;
            r_srcy   <= r_srcy4;
            r_crcp   <= r_crcp4;
        end
    end

    assign o_sp     = r_sp;
    assign o_cpcy   = r_cpcy;
    assign o_cpsy   = r_cpsy;
    assign o_crsy   = r_crsy;
    assign o_crcy   = r_crcy;
    assign o_srcp   = r_srcp;
    assign o_srsy   = r_srsy;
    assign o_srcy   = r_srcy;
    assign o_crcp   = r_crcp;
    assign o_srspcy = r_srspcy;
    assign o_srspsy = r_srspsy;
    assign o_crspcy = r_crspcy;
    assign o_crspsy = r_crspsy;

endmodule

### sv/e2bv_fmt.sv
// ----------------------------------------------------------------------------
// e2bv_fmt
// Final register stage: sums of the right and up components, clamp to unit
// range, rescale to Q1.14 and saturate. Doubles as the output register.
// ----------------------------------------------------------------------------
module e2bv_fmt #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  e2bv_pkg::t_stage_en         i_en,
    input  logic signed [FRAC_BITS+1:0] i_sp,
    input  logic signed [FRAC_BITS+1:0] i_cpcy,
    input  logic signed [FRAC_BITS+1:0] i_cpsy,
    input  logic signed [FRAC_BITS+1:0] i_crsy,
    input  logic signed [FRAC_BITS+1:0] i_crcy,
    input  logic signed [FRAC_BITS+1:0] i_srcp,
    input  logic signed [FRAC_BITS+1:0] i_srsy,
    input  logic signed [FRAC_BITS+1:0] i_srcy,
    input  logic signed [FRAC_BITS+1:0] i_crcp,
    input  logic signed [FRAC_BITS+1:0] i_srspcy,
    input  logic signed [FRAC_BITS+1:0] i_srspsy,
    input  logic signed [FRAC_BITS+1:0] i_crspcy,
    input  logic signed [FRAC_BITS+1:0] i_crspsy,
    output e2bv_pkg::t_basis            o_basis
);

    localparam int F      = FRAC_BITS;
    localparam int SW     = F + 3;
    localparam int MW     = (F + 2 > 16) ? F + 2 : 16;
    localparam int SH_DN  = (F > e2bv_pkg::OUT_FRAC) ? F - e2bv_pkg::OUT_FRAC : 0;
    localparam int SH_UP  = (F > e2bv_pkg::OUT_FRAC) ? 0 : e2bv_pkg::OUT_FRAC - F;
    localparam int RND    = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;
    localparam logic signed [SW-1:0] ONE_S = SW'(1) << F;

    // Clamp to unit range, rescale to Q1.14 rounding half away from zero
    function automatic logic signed [e2bv_pkg::OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0]          c;
        logic                          neg;
        logic [MW-1:0]                 m;
        logic [MW-1:0]                 ms;
        logic [e2bv_pkg::OUT_W-1:0]    r;
        c = v;
        if (v > ONE_S) begin
            c = ONE_S;
        end
        if (v < -ONE_S) begin
            c = -ONE_S;
        end
        neg = c[SW-1];
        m   = neg ? MW'(-c) : MW'(c);
        ms  = ((m + MW'(RND)) >> SH_DN) << SH_UP;
        if (ms > MW'(e2bv_pkg::OUT_ONE)) begin
            ms = MW'(e2bv_pkg::OUT_ONE);
        end
        r = e2bv_pkg::OUT_W'(ms);
        return neg ? $signed(-r) : $signed(r);
    endfunction

    // Widen a component for summing
    function automatic logic signed [SW-1:0] wide(input logic signed [F+1:0] a);
        return SW'(a);
    endfunction

    e2bv_pkg::t_basis n_basis;
    e2bv_pkg::t_basis r_basis;

    // Combine the terms of each component
    always_comb begin
        n_basis.forward_x = to_out(wide(i_cpcy));
        n_basis.forward_y = to_out(wide(i_cpsy));
        n_basis.forward_z = to_out(-wide(i_sp));
        n_basis.right_x   = to_out(wide(i_crsy) - wide(i_srspcy));
        n_basis.right_y   = to_out(-wide(i_srspsy) - wide(i_crcy));
        n_basis.right_z   = to_out(-wide(i_srcp));
        n_basis.up_x      = to_out(wide(i_crspcy) + wide(i_srsy));
        n_basis.up_y      = to_out(wide(i_crspsy) - wide(i_srcy));
        n_basis.up_z      = to_out(wide(i_crcp));
    end

    // Hold the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (i_en.fmt) begin
            r_basis <= n_basis;
        end
    end

    assign o_basis = r_basis;

endmodule

### sv/euler_to_basis_vectors_top.sv
// ----------------------------------------------------------------------------
// euler_to_basis_vectors_top
// Turns pitch, yaw and roll binary angles into forward, right and up unit
// vectors in signed Q1.14.
//
// Usage: angle words arrive on i_angles (valid/ready), one word each of
// pitch, yaw and roll, where 2^ANGLE_BITS is one full turn. Each word gives
// exactly one basis word of nine components on o_basis (valid/ready).
// Pipeline: an accepted word passes through the six register stages (index,
// table read, quadrant fold, two-factor products, three-factor products,
// sums and output format) before o_basis.valid rises for its result.
// Throughput: one word per cycle while o_basis.ready is high; every stage
// has its own valid bit and takes a new word whenever it is empty or the
// stage after it moves, so empty slots close up while the receiver stalls.
// Stall: with o_basis.ready low the last stage holds its word; i_angles.ready
// drops once all six stages are full, and nothing is lost or repeated.
// Reset: synchronous, active low; clears every valid bit and holds
// i_angles.ready low; the empty pipeline is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module euler_to_basis_vectors_top #(
    parameter int ANGLE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 10,
    parameter int FRAC_BITS       = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    e2bv_angles_if.sink        i_angles,
    e2bv_basis_if.source       o_basis
);

    localparam int FW = FRAC_BITS + 2;
    localparam int NS = 6;

    logic [NS-1:0]              r_vld;
    logic [NS-1:0]              n_vld;
    logic [NS-1:0]              en;
    e2bv_pkg::t_stage_en        stage_en;

    logic [e2bv_pkg::ANGLE_IN_W-1:0] angle [3];
    logic signed [FW-1:0]            sin_v [3];
    logic signed [FW-1:0]            cos_v [3];

    logic signed [FW-1:0] sp, cpcy, cpsy, crsy, crcy, srcp, srsy, srcy, crcp;
    logic signed [FW-1:0] srspcy, srspsy, crspcy, crspsy;
    e2bv_pkg::t_basis     basis;

    // Advance a stage when it is empty or its successor moves
    always_comb begin
        en[NS-1] = ~r_vld[NS-1] | o_basis.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_angles.valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign stage_en.idx  = en[0];
    assign stage_en.rom  = en[1];
    assign stage_en.quad = en[2];
    assign stage_en.prod = en[3];
    assign stage_en.term = en[4];
    assign stage_en.fmt  = en[5];

    // Refuse words while reset is held
    assign i_angles.ready = en[0] & i_rst_n;

    assign angle[0] = i_angles.pitch_angle;
    assign angle[1] = i_angles.yaw_angle;
    assign angle[2] = i_angles.roll_angle;

    e2bv_sincos #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .FRAC_BITS       (FRAC_BITS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_angle (angle),
        .o_sin   (sin_v),
        .o_cos   (cos_v)
    );

    e2bv_mult #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_sin    (sin_v),
        .i_cos    (cos_v),
        .o_sp     (sp),
        .o_cpcy   (cpcy),
        .o_cpsy   (cpsy),
        .o_crsy   (crsy),
        .o_crcy   (crcy),
        .o_srcp   (srcp),
        .o_srsy   (srsy),
        .o_srcy   (srcy),
        .o_crcp   (crcp),
        .o_srspcy (srspcy),
        .o_srspsy (srspsy),
        .o_crspcy (crspcy),
        .o_crspsy (crspsy)
    );

    e2bv_fmt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fmt (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_sp     (sp),
        .i_cpcy   (cpcy),
        .i_cpsy   (cpsy),
        .i_crsy   (crsy),
        .i_crcy   (crcy),
        .i_srcp   (srcp),
        .i_srsy   (srsy),
        .i_srcy   (srcy),
        .i_crcp   (crcp),
        .i_srspcy (srspcy),
        .i_srspsy (srspsy),
        .i_crspcy (crspcy),
        .i_crspsy (crspsy),
        .o_basis  (basis)
    );

    // Drive the result word
    assign o_basis.valid     = r_vld[NS-1];
    assign o_basis.forward_x = basis.forward_x;
    assign o_basis.forward_y = basis.forward_y;
    assign o_basis.forward_z = basis.forward_z;
    assign o_basis.right_x   = basis.right_x;
    assign o_basis.right_y   = basis.right_y;
    assign o_basis.right_z   = basis.right_z;
    assign o_basis.up_x      = basis.up_x;
    assign o_basis.up_y      = basis.up_y;
    assign o_basis.up_z      = basis.up_z;

endmodule
